/* rtl/pgc_pkg.sv */
// ----------------------------------------------------------------------------
// Parking gate controller package
// Shared payload types, state and event codes, register indexes and reset
// values for the parking gate controller.
// ----------------------------------------------------------------------------
package pgc_pkg;

  // Widths of the fixed fields.
  localparam int ECHO_W     = 20;
  localparam int LIGHT_W    = 10;
  localparam int RADIO_W    = 8;
  localparam int TIME_W     = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Register reset values.
  localparam logic [LIGHT_W-1:0]   LIGHT_THRESHOLD_RST = LIGHT_W'(300);
  localparam logic [TIMEOUT_W-1:0] GATE_TIMEOUT_RST    = TIMEOUT_W'(5000);
  localparam logic [ECHO_W-1:0]    ECHO_LIMIT_RST      = ECHO_W'(1000);

  // Radio byte that requests the gate to open.
  localparam logic [RADIO_W-1:0] RADIO_OPEN_CODE = RADIO_W'(3);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_THRESHOLD = 2'd0,
    CFG_GATE_TIMEOUT    = 2'd1,
    CFG_ECHO_LIMIT      = 2'd2
  } pgc_cfg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INITIAL  = 3'd0,
    ST_WAITING  = 3'd1,
    ST_FULL     = 3'd2,
    ST_LEAVING  = 3'd3,
    ST_SERVING  = 3'd4,
    ST_ENTERING = 3'd5
  } pgc_state_t;

  // Events derived from one tick.
  typedef enum logic [3:0] {
    EV_DARK         = 4'd0,
    EV_VACATED      = 4'd1,
    EV_OPEN         = 4'd2,
    EV_CAR_AT_GATE  = 4'd3,
    EV_GATE_TIMEOUT = 4'd4,
    EV_SLOTS_IDLE   = 4'd5,
    EV_NO_SPACE     = 4'd6,
    EV_SLOT_TAKEN   = 4'd7,
    EV_DAYLIGHT     = 4'd8
  } pgc_event_t;

  // One sensing tick.
  typedef struct packed {
    logic [ECHO_W-1:0]  echo_slot_one;
    logic [ECHO_W-1:0]  echo_slot_two;
    logic [ECHO_W-1:0]  echo_gate;
    logic [LIGHT_W-1:0] light_level;
    logic               button_pressed;
    logic               radio_valid;
    logic [RADIO_W-1:0] radio_code;
    logic [TIME_W-1:0]  now_ms;
  } pgc_item_t;

  // One controller result.
  typedef struct packed {
    logic [2:0] ctrl_state;
    logic [3:0] tick_event;
    logic       gate_raised;
    logic       night_lamp;
    logic       led_slot_one;
    logic       led_slot_two;
  } pgc_result_t;

  // A tick reduced to the facts the controller needs.
  typedef struct packed {
    logic              pres_one;
    logic              pres_two;
    logic              gate_pres;
    logic              day;
    logic              open_req;
    logic [TIME_W-1:0] now_ms;
  } pgc_cls_t;

  // Actions of one controller transition.
  typedef struct packed {
    logic show;
    logic gate_set;
    logic gate_clr;
    logic lamp_apply;
    logic arm;
  } pgc_act_t;

endpackage

/* rtl/parking_gate_controller_unit.sv */
// ----------------------------------------------------------------------------
// Parking gate controller unit
// Top level: configuration registers, front classification stage, queue and
// back controller stage with its output register.
// ----------------------------------------------------------------------------
// Throughput: one tick per cycle while the output side does not stall.
// Path: a tick passes the front register, a queue entry and the output
// register, in that order, before its result is presented.
// Reset: synchronous; restores register defaults, the initial controller
// state, and empties the front stage, the queue and the output register.
module parking_gate_controller_unit import pgc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  pgc_item_t             item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output pgc_result_t           result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LIGHT_W-1:0]   light_threshold;
  logic [TIMEOUT_W-1:0] gate_timeout_ms;
  logic [ECHO_W-1:0]    echo_limit_us;

  logic     f_valid;
  logic     f_stall;
  pgc_cls_t f_cls;
  logic     q_valid;
  logic     q_stall;
  pgc_cls_t q_cls;

  // Configuration registers; other indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold <= LIGHT_THRESHOLD_RST;
      gate_timeout_ms <= GATE_TIMEOUT_RST;
      echo_limit_us   <= ECHO_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIGHT_THRESHOLD: light_threshold <= cfg_data[LIGHT_W-1:0];
        CFG_GATE_TIMEOUT:    gate_timeout_ms <= cfg_data[TIMEOUT_W-1:0];
        CFG_ECHO_LIMIT:      echo_limit_us   <= cfg_data[ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  // Front part: classify each transfer.
  pgc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .light_threshold (light_threshold),
    .echo_limit_us   (echo_limit_us),
    .cls_valid       (f_valid),
    .cls_stall       (f_stall),
    .cls             (f_cls)
  );

  // Queue between the two parts.
  pgc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_data  (f_cls),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_cls)
  );

  // Back part: event, transition and result register.
  pgc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cls_valid       (q_valid),
    .cls_stall       (q_stall),
    .cls             (q_cls),
    .gate_timeout_ms (gate_timeout_ms),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result)
  );

endmodule

/* rtl/pgc_front.sv */
// ----------------------------------------------------------------------------
// Parking gate controller front part
// Takes sensing ticks and reduces them to presence, daylight and open-request
// flags in a register stage ahead of the queue.
// ----------------------------------------------------------------------------
module pgc_front import pgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  pgc_item_t            item,
  input  logic [LIGHT_W-1:0]   light_threshold,
  input  logic [ECHO_W-1:0]    echo_limit_us,
  output logic                 cls_valid,
  input  logic                 cls_stall,
  output pgc_cls_t             cls
);

  pgc_cls_t cls_next;

  // Classify the incoming tick against the configured limits.
  always_comb begin
    cls_next.pres_one  = item.echo_slot_one < echo_limit_us;
    cls_next.pres_two  = item.echo_slot_two < echo_limit_us;
    cls_next.gate_pres = item.echo_gate < echo_limit_us;
    cls_next.day       = item.light_level > light_threshold;
    cls_next.open_req  = item.button_pressed ||
                         (item.radio_valid && (item.radio_code == RADIO_OPEN_CODE));
    cls_next.now_ms    = item.now_ms;
  end

  // The stage holds while its content cannot move on.
  assign item_stall = cls_valid && cls_stall;

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (!item_stall) begin
      cls_valid <= item_valid;
    end
  end

  // Stage payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      cls <= cls_next;
    end
  end

endmodule

/* rtl/pgc_queue.sv */
// ----------------------------------------------------------------------------
// Parking gate controller queue
// Short first-in first-out queue of classified ticks between the front and
// back parts, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module pgc_queue import pgc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_stall,
  input  pgc_cls_t wr_data,
  output logic     rd_valid,
  input  logic     rd_stall,
  output pgc_cls_t rd_data
);

  pgc_cls_t            entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                push;
  logic                pop;
  logic                full;

  // Handshake on both sides; a full queue still takes a transfer when one leaves.
  assign full     = count == Q_CNT_W'(Q_DEPTH);
  assign rd_valid = count != '0;
  assign pop      = rd_valid && !rd_stall;
  assign wr_stall = full && !pop;
  assign push     = wr_valid && !wr_stall;
  assign rd_data  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/pgc_back.sv */
// ----------------------------------------------------------------------------
// Parking gate controller back part
// Derives the prioritized event from a classified tick and the kept state,
// makes the controller transition and holds the result in an output register.
// ----------------------------------------------------------------------------
module pgc_back import pgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cls_valid,
  output logic                 cls_stall,
  input  pgc_cls_t             cls,
  input  logic [TIMEOUT_W-1:0] gate_timeout_ms,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pgc_result_t          result
);

  pgc_state_t        state;
  pgc_state_t        state_next;
  logic [1:0]        slot_free;
  logic [1:0]        pending_led;
  logic [1:0]        shown_led;
  logic              daylight_flag;
  logic              timer_armed;
  logic [TIME_W-1:0] timer_start;
  logic              gate_up;
  logic              lamp_on;

  logic [1:0]        pres;
  logic [1:0]        left_slot;
  logic [1:0]        came_slot;
  logic [1:0]        pending_led_next;
  logic [1:0]        shown_led_next;
  logic [TIME_W-1:0] elapsed;
  logic              timed_out;
  logic              armed_derived;
  logic              timer_armed_next;
  logic              gate_up_next;
  logic              lamp_on_next;
  pgc_event_t        ev;
  pgc_act_t          act;
  logic              ready;
  logic              take;

  // A tick is taken when the output register is free or being emptied.
  assign ready     = !result_valid || !result_stall;
  assign cls_stall = !ready;
  assign take      = cls_valid && ready;

  // Slot presence changes against the kept occupancy.
  assign pres      = {cls.pres_two, cls.pres_one};
  assign left_slot = ~slot_free & ~pres;
  assign came_slot = slot_free & pres;
  assign elapsed   = cls.now_ms - timer_start;
  assign timed_out = elapsed > {{(TIME_W - TIMEOUT_W){1'b0}}, gate_timeout_ms};

  // Pending LEDs follow each slot change.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (came_slot[i]) begin
        pending_led_next[i] = 1'b0;
      end else if (left_slot[i]) begin
        pending_led_next[i] = 1'b1;
      end else begin
        pending_led_next[i] = pending_led[i];
      end
    end
  end

  // Event priority, lowest first; later tests override earlier ones.
  always_comb begin
    armed_derived = timer_armed;
    ev = EV_SLOTS_IDLE;
    if (|left_slot) begin
      ev = EV_VACATED;
    end
    if (|came_slot) begin
      ev = EV_SLOT_TAKEN;
    end
    if (&pres) begin
      ev = EV_NO_SPACE;
    end
    if (cls.day != daylight_flag) begin
      ev = cls.day ? EV_DAYLIGHT : EV_DARK;
    end
    if (timer_armed) begin
      if (cls.gate_pres) begin
        ev = EV_CAR_AT_GATE;
        armed_derived = 1'b0;
      end else if (timed_out) begin
        ev = EV_GATE_TIMEOUT;
        armed_derived = 1'b0;
      end
    end
    if (cls.open_req) begin
      ev = EV_OPEN;
    end
  end

  // Controller next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INITIAL: begin
        if (ev == EV_DARK || ev == EV_DAYLIGHT) begin
          state_next = ST_WAITING;
        end
      end
      ST_WAITING: begin
        if (ev == EV_OPEN) begin
          state_next = ST_SERVING;
        end else if (ev == EV_VACATED) begin
          state_next = ST_LEAVING;
        end
      end
      ST_SERVING: begin
        if (ev == EV_CAR_AT_GATE) begin
          state_next = ST_ENTERING;
        end else if (ev == EV_GATE_TIMEOUT) begin
          state_next = ST_WAITING;
        end
      end
      ST_ENTERING: begin
        if (ev == EV_SLOT_TAKEN) begin
          state_next = ST_WAITING;
        end else if (ev == EV_NO_SPACE) begin
          state_next = ST_FULL;
        end
      end
      ST_FULL: begin
        if (ev == EV_VACATED) begin
          state_next = ST_LEAVING;
        end
      end
      ST_LEAVING: begin
        if (ev == EV_SLOTS_IDLE || ev == EV_SLOT_TAKEN) begin
          state_next = ST_WAITING;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Controller actions for the transition.
  always_comb begin
    act = '0;
    unique case (state)
      ST_INITIAL: begin
        act.lamp_apply = ev == EV_DARK || ev == EV_DAYLIGHT;
      end
      ST_WAITING: begin
        if (ev == EV_OPEN) begin
          act.gate_set = 1'b1;
          act.arm      = 1'b1;
        end else if (ev == EV_VACATED) begin
          act.show = 1'b1;
        end else begin
          act.lamp_apply = 1'b1;
        end
      end
      ST_SERVING: begin
        act.gate_clr = ev == EV_CAR_AT_GATE || ev == EV_GATE_TIMEOUT;
      end
      ST_ENTERING: begin
        act.show = ev == EV_SLOT_TAKEN || ev == EV_NO_SPACE;
      end
      ST_FULL: begin
        if (ev == EV_VACATED) begin
          act.show = 1'b1;
        end else begin
          act.lamp_apply = 1'b1;
        end
      end
      ST_LEAVING: begin
        act.show = ev == EV_SLOTS_IDLE || ev == EV_SLOT_TAKEN;
      end
      default: begin
        act = '0;
      end
    endcase
  end

  // Values of the kept outputs after the transition.
  always_comb begin
    shown_led_next   = act.show ? pending_led_next : shown_led;
    gate_up_next     = act.gate_set ? 1'b1 : (act.gate_clr ? 1'b0 : gate_up);
    timer_armed_next = act.arm || armed_derived;
    lamp_on_next     = lamp_on;
    if (act.lamp_apply) begin
      if (ev == EV_DARK) begin
        lamp_on_next = 1'b1;
      end else if (ev == EV_DAYLIGHT) begin
        lamp_on_next = 1'b0;
      end
    end
  end

  // Controller state, updated once per taken tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INITIAL;
      slot_free     <= 2'b11;
      pending_led   <= 2'b11;
      shown_led     <= 2'b11;
      daylight_flag <= 1'b1;
      timer_armed   <= 1'b0;
      timer_start   <= '0;
      gate_up       <= 1'b0;
      lamp_on       <= 1'b0;
    end else if (take) begin
      state         <= state_next;
      slot_free     <= ~pres;
      pending_led   <= pending_led_next;
      shown_led     <= shown_led_next;
      daylight_flag <= cls.day;
      timer_armed   <= timer_armed_next;
      gate_up       <= gate_up_next;
      lamp_on       <= lamp_on_next;
      if (act.arm) begin
        timer_start <= cls.now_ms;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= cls_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      result.ctrl_state   <= state_next;
      result.tick_event   <= ev;
      result.gate_raised  <= gate_up_next;
      result.night_lamp   <= lamp_on_next;
      result.led_slot_one <= shown_led_next[0];
      result.led_slot_two <= shown_led_next[1];
    end
  end

endmodule
